FILE: hw/rtl/otw_pkg.sv
// types, constants and constant functions for the key to tonewheel mixer
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package otw_pkg;

	localparam int NUM_DRAWBARS = 9;
	localparam int NUM_WHEELS   = 91;

	localparam int OP_W   = 2;
	localparam int KEY_W  = 6;
	localparam int BAR_W  = 4;
	localparam int LVL_W  = 4;
	localparam int WHL_W  = 7;
	localparam int VOL_W  = 15;
	localparam int G_W    = 17;
	localparam int V_W    = 10;
	localparam int ACC_W  = 29;
	localparam int PROD_W = ACC_W + V_W;
	localparam int M_W    = 40;
	localparam int QB     = 16;
	localparam int NUM_W  = M_W + QB;

	localparam logic [OP_W-1:0] OP_KEY  = 2'd0;
	localparam logic [OP_W-1:0] OP_BAR  = 2'd1;
	localparam logic [OP_W-1:0] OP_READ = 2'd2;

	localparam logic [LVL_W-1:0] LVL_MAX = 4'd8;
	localparam logic [VOL_W-1:0] Q14_ONE = 15'd16384;

	localparam logic [G_W-1:0] G10  = 17'd104858;
	localparam logic [G_W-1:0] G15  = 17'd69905;
	localparam logic [G_W-1:0] G24  = 17'd43691;
	localparam logic [G_W-1:0] G34  = 17'd30840;
	localparam logic [G_W-1:0] G50  = 17'd20972;
	localparam logic [G_W-1:0] G100 = 17'd10486;

	localparam logic [V_W-1:0] VOLTS [0:NUM_WHEELS] = '{
		10'd0,
		10'd700, 10'd692, 10'd683, 10'd673, 10'd664, 10'd655,
		10'd645, 10'd636, 10'd626, 10'd617, 10'd608, 10'd600,
		10'd150, 10'd146, 10'd143, 10'd140, 10'd136, 10'd133,
		10'd130, 10'd126, 10'd123, 10'd120, 10'd116, 10'd113,
		10'd110, 10'd110, 10'd110, 10'd110, 10'd110, 10'd110,
		10'd110, 10'd110, 10'd110, 10'd110, 10'd110, 10'd110,
		10'd111, 10'd112, 10'd113, 10'd114, 10'd115, 10'd117,
		10'd118, 10'd120, 10'd122, 10'd125, 10'd128, 10'd130,
		10'd132, 10'd134, 10'd136, 10'd140, 10'd142, 10'd145,
		10'd147, 10'd151, 10'd152, 10'd156, 10'd158, 10'd160,
		10'd163, 10'd166, 10'd170, 10'd173, 10'd177, 10'd180,
		10'd185, 10'd188, 10'd192, 10'd194, 10'd196, 10'd198,
		10'd200, 10'd200, 10'd200, 10'd200, 10'd200, 10'd200,
		10'd200, 10'd200, 10'd200, 10'd200, 10'd200, 10'd200,
		10'd200, 10'd197, 10'd193, 10'd190, 10'd187, 10'd183,
		10'd180
	};

	typedef struct packed {
		logic write_key;
		logic write_bar;
		logic load;
		logic step;
		logic mul;
		logic rmul;
		logic est;
		logic back;
		logic fix;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
	} status_t;

	function automatic logic [V_W-1:0] volts(input logic [WHL_W-1:0] w);
		logic [V_W-1:0] v;
		v = '0;
		if (w <= WHL_W'(NUM_WHEELS))
			v = VOLTS[w];
		return v;
	endfunction

	function automatic logic [WHL_W-1:0] interval(input logic [BAR_W-1:0] d);
		logic [WHL_W-1:0] r;
		unique case (d)
			4'd2:    r = 7'd19;
			4'd3:    r = 7'd12;
			4'd4:    r = 7'd24;
			4'd5:    r = 7'd31;
			4'd6:    r = 7'd36;
			4'd7:    r = 7'd40;
			4'd8:    r = 7'd43;
			4'd9:    r = 7'd48;
			default: r = 7'd0;
		endcase
		return r;
	endfunction

	// fold by octaves into 13..91
	function automatic logic [WHL_W-1:0] wheel_of(input logic [KEY_W-1:0] k,
			input logic [BAR_W-1:0] d);
		logic [WHL_W-1:0] t;
		t = WHL_W'(k) + interval(d);
		if (t < 7'd13)
			t = t + 7'd12;
		else if (t > 7'd103)
			t = t - 7'd24;
		else if (t > 7'd91)
			t = t - 7'd12;
		return t;
	endfunction

	function automatic logic [G_W-1:0] conductance(input logic [KEY_W-1:0] k,
			input logic [BAR_W-1:0] d);
		logic [G_W-1:0] g;
		unique case (d)
			4'd1: begin
				if (k < 6'd11)      g = G100;
				else if (k < 6'd17) g = G50;
				else if (k < 6'd25) g = G34;
				else if (k < 6'd37) g = G24;
				else if (k < 6'd49) g = G15;
				else                g = G10;
			end
			4'd2: begin
				// no middle step on this taper
				if (k < 6'd15)      g = G34;
				else if (k < 6'd39) g = G24;
				else                g = G10;
			end
			4'd3: begin
				if (k < 6'd16)      g = G50;
				else if (k < 6'd24) g = G34;
				else if (k < 6'd38) g = G24;
				else if (k < 6'd50) g = G15;
				else                g = G10;
			end
			4'd4: begin
				if (k < 6'd14)      g = G34;
				else if (k < 6'd40) g = G24;
				else                g = G34;
			end
			4'd5: begin
				if (k < 6'd13)      g = G10;
				else if (k < 6'd21) g = G15;
				else if (k < 6'd41) g = G24;
				else if (k < 6'd53) g = G34;
				else                g = G50;
			end
			4'd6: begin
				if (k < 6'd12)      g = G10;
				else if (k < 6'd21) g = G15;
				else if (k < 6'd42) g = G24;
				else if (k < 6'd56) g = G34;
				else                g = G50;
			end
			4'd7: begin
				if (k < 6'd19)      g = G10;
				else if (k < 6'd43) g = G24;
				else if (k < 6'd52) g = G34;
				else                g = G50;
			end
			4'd8: begin
				if (k < 6'd44)      g = G24;
				else if (k < 6'd49) g = G34;
				else                g = G50;
			end
			default: begin
				if (k < 6'd44) g = G24;
				else           g = G50;
			end
		endcase
		return g;
	endfunction

	// full-scale sum, every key down and every drawbar at 8
	function automatic logic [M_W-1:0] full_scale(input int nk);
		logic [63:0] m;
		logic [KEY_W-1:0] kk;
		logic [BAR_W-1:0] dd;
		m = '0;
		for (int k = 1; k <= nk; k++) begin
			for (int d = 1; d <= NUM_DRAWBARS; d++) begin
				kk = KEY_W'(k);
				dd = BAR_W'(d);
				m = m + 64'd8 * 64'(conductance(kk, dd)) * 64'(volts(wheel_of(kk, dd)));
			end
		end
		return m[M_W-1:0];
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/otw_ctrl.sv
// sequencer for the mixer: scan, multiply, reciprocal scaling and output handshake
// depends on otw_pkg
`timescale 1ns / 1ps
`default_nettype none
module otw_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	input  wire logic [otw_pkg::OP_W-1:0] op,
	output logic                          in_ready,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	input  wire otw_pkg::status_t         status,
	output otw_pkg::cmd_t                 cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MUL,
		ST_RMUL,
		ST_EST,
		ST_BACK,
		ST_FIX,
		ST_FIN
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   out_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		cmd           = '0;
		cmd.write_key = accept && (op == otw_pkg::OP_KEY);
		cmd.write_bar = accept && (op == otw_pkg::OP_BAR);
		cmd.load      = accept && (op == otw_pkg::OP_READ);
		cmd.step      = (state_q == ST_SCAN);
		cmd.mul       = (state_q == ST_MUL);
		cmd.rmul      = (state_q == ST_RMUL);
		cmd.est       = (state_q == ST_EST);
		cmd.back      = (state_q == ST_BACK);
		cmd.fix       = (state_q == ST_FIX);
		cmd.out_load  = (state_q == ST_FIN) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && op == otw_pkg::OP_READ)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (status.scan_last)
						state_q <= ST_MUL;
				end
				ST_MUL:  state_q <= ST_RMUL;
				ST_RMUL: state_q <= ST_EST;
				ST_EST:  state_q <= ST_BACK;
				ST_BACK: state_q <= ST_FIX;
				ST_FIX:  state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !in_ready) else $error("ready while busy");
	a_read_starts_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_SCAN) else $error("read did not start scan");
	a_out_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q) else $error("result lost");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/otw_dp.sv
// datapath: key and drawbar state, pair scan accumulator, reciprocal scaling
// depends on otw_pkg
`timescale 1ns / 1ps
`default_nettype none
module otw_dp #(
	parameter int NUM_KEYS = 61
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire otw_pkg::cmd_t               cmd,
	output otw_pkg::status_t                 status,
	input  wire logic [otw_pkg::KEY_W-1:0]   key_index,
	input  wire logic                        key_down,
	input  wire logic [otw_pkg::BAR_W-1:0]   drawbar_index,
	input  wire logic [otw_pkg::LVL_W-1:0]   drawbar_level,
	input  wire logic [otw_pkg::WHL_W-1:0]   wheel_index,
	output logic [otw_pkg::VOL_W-1:0]        volume,
	output logic                             index_valid
);

	localparam int KW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int NW = otw_pkg::NUM_W + 1;
	localparam logic [otw_pkg::M_W-1:0] FULL = otw_pkg::full_scale(NUM_KEYS);
	localparam logic [otw_pkg::KEY_W-1:0] LAST_KEY = otw_pkg::KEY_W'(NUM_KEYS);
	localparam logic [otw_pkg::BAR_W-1:0] LAST_BAR = otw_pkg::BAR_W'(otw_pkg::NUM_DRAWBARS);
	// floor(2^56 / full scale); the estimate is at most one below the quotient
	localparam logic [31:0] RECIP = 32'((64'd1 << 56) / 64'(FULL));
	localparam logic [NW-1:0] FULL_X = NW'(FULL);
	localparam logic [NW-1:0] SAT_NUM = FULL_X * (NW'(otw_pkg::Q14_ONE) + NW'(1));
	localparam logic [19:0] F_LO = FULL[19:0];
	localparam logic [19:0] F_HI = FULL[otw_pkg::M_W-1:20];

	logic [NUM_KEYS-1:0]                keys_q;
	logic [otw_pkg::LVL_W-1:0]          bars_q [otw_pkg::NUM_DRAWBARS];
	logic [otw_pkg::KEY_W-1:0]          k_q;
	logic [otw_pkg::BAR_W-1:0]          d_q;
	logic [otw_pkg::WHL_W-1:0]          wheel_q;
	logic                               valid_q;
	logic [otw_pkg::ACC_W-1:0]          acc_q;
	logic [otw_pkg::PROD_W-1:0]         prod_q;
	logic [59:0]                        pl_q;
	logic [59:0]                        ph_q;
	logic [otw_pkg::VOL_W-1:0]          qe_q;
	logic                               sat_q;
	logic [NW-1:0]                      prd_q;
	logic [otw_pkg::VOL_W-1:0]          res_q;
	logic [otw_pkg::VOL_W-1:0]          volume_q;
	logic                               index_valid_q;

	logic [otw_pkg::LVL_W-1:0]          lvl;
	logic                               hit;
	logic [NW-1:0]                      num;
	logic [87:0]                        est_sum;
	logic [NW-1:0]                      diff;

	assign lvl = bars_q[d_q - 4'd1];
	assign hit = keys_q[KW'(k_q - 6'd1)] && (lvl != '0)
		&& (otw_pkg::wheel_of(k_q, d_q) == wheel_q);

	assign num = NW'({prod_q, 14'd0}) + NW'(FULL >> 1);
	assign est_sum = {ph_q, 28'd0} + 88'(pl_q);
	assign diff = num - prd_q;

	assign status.scan_last = (k_q == LAST_KEY) && (d_q == LAST_BAR);

	assign volume      = volume_q;
	assign index_valid = index_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keys_q <= '0;
			for (int i = 0; i < otw_pkg::NUM_DRAWBARS; i++)
				bars_q[i] <= '0;
		end else begin
			if (cmd.write_key && key_index >= 6'd1 && key_index <= LAST_KEY)
				keys_q[KW'(key_index - 6'd1)] <= key_down;
			if (cmd.write_bar && drawbar_index >= 4'd1 && drawbar_index <= LAST_BAR)
				bars_q[drawbar_index - 4'd1] <=
					(drawbar_level > otw_pkg::LVL_MAX) ? otw_pkg::LVL_MAX : drawbar_level;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q     <= 6'd1;
			d_q     <= 4'd1;
			acc_q   <= '0;
			wheel_q <= wheel_index;
			valid_q <= (wheel_index >= 7'd1)
				&& (wheel_index <= otw_pkg::WHL_W'(otw_pkg::NUM_WHEELS));
		end
		if (cmd.step) begin
			if (hit)
				acc_q <= acc_q + otw_pkg::ACC_W'(lvl)
					* otw_pkg::ACC_W'(otw_pkg::conductance(k_q, d_q));
			if (d_q == LAST_BAR) begin
				d_q <= 4'd1;
				k_q <= k_q + 6'd1;
			end else begin
				d_q <= d_q + 4'd1;
			end
		end
		if (cmd.mul)
			prod_q <= otw_pkg::PROD_W'(otw_pkg::volts(wheel_q)) * otw_pkg::PROD_W'(acc_q);
		// numerator times reciprocal, split in two halves
		if (cmd.rmul) begin
			pl_q <= 60'(num[27:0]) * 60'(RECIP);
			ph_q <= 60'(num[55:28]) * 60'(RECIP);
		end
		if (cmd.est) begin
			qe_q  <= est_sum[70:56];
			sat_q <= (num >= SAT_NUM);
		end
		if (cmd.back)
			prd_q <= NW'(qe_q) * NW'(F_LO) + ((NW'(qe_q) * NW'(F_HI)) << 20);
		// bump the estimate when the remainder still holds a full divisor, or saturate to Q14 one
		if (cmd.fix) begin
			if (sat_q)
				res_q <= otw_pkg::Q14_ONE;
			else
				res_q <= qe_q + otw_pkg::VOL_W'(diff >= FULL_X);
		end
		if (cmd.out_load) begin
			index_valid_q <= valid_q;
			volume_q      <= res_q;
		end
	end

`ifndef SYNTH
	a_fix_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fix && !sat_q |-> diff < (FULL_X << 1))
		else $error("quotient estimate off by more than one");
	a_scan_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step && d_q == LAST_BAR && !status.scan_last |=> d_q == 4'd1)
		else $error("drawbar counter did not wrap");
	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul && !valid_q |=> prod_q == '0) else $error("invalid wheel fed");
`endif

endmodule
`default_nettype wire

FILE: hw/rtl/organ_key_to_tonewheel_mixer.sv
// channel  | dir | payload
// s_axis   | in  | operation, key_index, key_down, drawbar_index, drawbar_level, wheel_index
// m_axis   | out | volume (tdata), index_valid (tuser)
//
// key and drawbar words are written as they are accepted; a read scans all NUM_KEYS*9
// key and drawbar pairs (one key and drawbar pair a cycle), then steps through the multiply,
// reciprocal multiply, estimate, back-multiply and correction states and an output state.
// one word in flight; a finished result waits in the output register while the next word
// is accepted, and the output state stalls while that register is still full. reset
// clears all keys and drawbars.
`timescale 1ns / 1ps
`default_nettype none
module organ_key_to_tonewheel_mixer #(
	parameter int NUM_KEYS = 61
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// operation, key_index, key_down, drawbar_index, drawbar_level, wheel_index
	input  wire logic [23:0] s_tdata,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// volume
	output logic [15:0]      m_tdata,
	// index_valid
	output logic [0:0]       m_tuser
);

	otw_pkg::cmd_t                   cmd;
	otw_pkg::status_t                status;
	logic [otw_pkg::VOL_W-1:0]       volume;
	logic                            index_valid;

	otw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.op        (s_tdata[1:0]),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.status    (status),
		.cmd       (cmd)
	);

	otw_dp #(
		.NUM_KEYS (NUM_KEYS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.key_index     (s_tdata[7:2]),
		.key_down      (s_tdata[8]),
		.drawbar_index (s_tdata[12:9]),
		.drawbar_level (s_tdata[16:13]),
		.wheel_index   (s_tdata[23:17]),
		.volume        (volume),
		.index_valid   (index_valid)
	);

	assign m_tdata = {1'b0, volume};
	assign m_tuser = index_valid;

`ifndef SYNTH
	a_invalid_zero_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |-> m_tdata == 16'd0) else $error("bad invalid word");
	a_volume_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata <= 16'd16384) else $error("volume out of range");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output word dropped");
`endif

endmodule
`default_nettype wire
